### design/spq_pkg.sv
// Package for the sorted priority queue: sizes, operation and status codes,
// and the entry and command types shared by the cell chain and the top level.
// No dependencies.
package spq_pkg;

	localparam int CAPACITY       = 16;
	localparam int DATA_WIDTH     = 32;
	localparam int PRIORITY_WIDTH = 16;
	localparam int COUNT_WIDTH    = $clog2(CAPACITY + 1);

	localparam logic [1:0] ACT_ENQUEUE = 2'd0;
	localparam logic [1:0] ACT_DEQUEUE = 2'd1;
	localparam logic [1:0] ACT_PEEK    = 2'd2;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic [DATA_WIDTH-1:0]     data;
		logic [PRIORITY_WIDTH-1:0] prio;
	} entry_t;

	typedef struct packed {
		logic   enq;
		logic   deq;
		entry_t item;
	} cmd_t;

endpackage

### design/spq_cell.sv
// One slot of the sorted queue chain: holds an entry, compares it with the
// entry being inserted, and shifts toward the back on insert or the front on removal.
// Depends on spq_pkg.
module spq_cell (
	input  logic            clk,
	input  spq_pkg::cmd_t   cmd,
	input  logic            occupied,
	input  spq_pkg::entry_t prev_entry,
	input  logic            prev_place,
	input  spq_pkg::entry_t next_entry,
	output spq_pkg::entry_t entry,
	output logic            place
);

	spq_pkg::entry_t entry_q;
	spq_pkg::entry_t entry_d;

	assign place = !occupied || ($signed(entry_q.prio) < $signed(cmd.item.prio));
	assign entry = entry_q;

	always_comb begin
		entry_d = entry_q;
		if (cmd.enq) begin
			if (prev_place) begin
				entry_d = prev_entry;
			end else if (place) begin
				entry_d = cmd.item;
			end
		end else if (cmd.deq) begin
			entry_d = next_entry;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

### design/sorted_priority_queue.sv
// Sorted priority queue of spq_pkg::CAPACITY entries, highest priority at the
// front, equal priorities served first-in first-out. Every operation (enqueue,
// dequeue, peek) works on all cells in parallel (compare and shift), so a
// command beat is accepted every cycle while cmd_stall is low, and its result
// beat appears on the next cycle from an output register. cmd_stall rises only
// while that result register is full and rsp_stall holds it.
module sorted_priority_queue (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	output logic                               cmd_stall,
	input  logic [1:0]                         action,
	input  logic [spq_pkg::DATA_WIDTH-1:0]     data_in,
	input  logic [spq_pkg::PRIORITY_WIDTH-1:0] priority_in,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic [spq_pkg::DATA_WIDTH-1:0]     data_out,
	output logic [1:0]                         status,
	output logic                               is_empty,
	output logic [spq_pkg::COUNT_WIDTH-1:0]    entry_count
);

	localparam logic [spq_pkg::COUNT_WIDTH-1:0] FULL_COUNT =
		spq_pkg::COUNT_WIDTH'(spq_pkg::CAPACITY);

	logic                               accept;
	logic [spq_pkg::COUNT_WIDTH-1:0]    count_q;
	logic [spq_pkg::COUNT_WIDTH-1:0]    count_d;
	logic                               rsp_valid_q;
	logic [spq_pkg::DATA_WIDTH-1:0]     data_out_q;
	logic [1:0]                         status_q;
	logic [spq_pkg::DATA_WIDTH-1:0]     data_d;
	logic [1:0]                         status_d;
	logic                               is_full;
	logic                               no_entries;
	spq_pkg::cmd_t                      cmd;
	spq_pkg::entry_t                    cell_entry [spq_pkg::CAPACITY];
	logic                               cell_place [spq_pkg::CAPACITY];

	assign cmd_stall  = rsp_valid_q && rsp_stall;
	assign accept     = cmd_valid && !cmd_stall;
	assign is_full    = (count_q == FULL_COUNT);
	assign no_entries = (count_q == '0);

	always_comb begin
		cmd.enq       = accept && (action == spq_pkg::ACT_ENQUEUE) && !is_full;
		cmd.deq       = accept && (action == spq_pkg::ACT_DEQUEUE) && !no_entries;
		cmd.item.data = data_in;
		cmd.item.prio = priority_in;
	end

	always_comb begin
		count_d  = count_q;
		data_d   = '0;
		status_d = spq_pkg::STATUS_OK;
		unique case (action) inside
			spq_pkg::ACT_ENQUEUE: begin
				if (is_full) begin
					status_d = spq_pkg::STATUS_FULL;
				end else begin
					count_d = count_q + 1'b1;
				end
			end
			spq_pkg::ACT_DEQUEUE, spq_pkg::ACT_PEEK: begin
				if (no_entries) begin
					status_d = spq_pkg::STATUS_EMPTY;
				end else begin
					data_d = cell_entry[0].data;
					if (action == spq_pkg::ACT_DEQUEUE) begin
						count_d = count_q - 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	genvar gi;
	generate
		for (gi = 0; gi < spq_pkg::CAPACITY; gi++) begin : g_cell
			spq_pkg::entry_t prev_entry;
			spq_pkg::entry_t next_entry;
			logic            prev_place;
			logic            occupied;

			assign occupied = (spq_pkg::COUNT_WIDTH'(gi) < count_q);

			if (gi == 0) begin : g_head
				assign prev_entry = cmd.item;
				assign prev_place = 1'b0;
			end else begin : g_body
				assign prev_entry = cell_entry[gi-1];
				assign prev_place = cell_place[gi-1];
			end

			if (gi == spq_pkg::CAPACITY - 1) begin : g_tail
				assign next_entry = cell_entry[gi];
			end else begin : g_mid
				assign next_entry = cell_entry[gi+1];
			end

			spq_cell u_cell (
				.clk        (clk),
				.cmd        (cmd),
				.occupied   (occupied),
				.prev_entry (prev_entry),
				.prev_place (prev_place),
				.next_entry (next_entry),
				.entry      (cell_entry[gi]),
				.place      (cell_place[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_out_q <= data_d;
			status_q   <= status_d;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign data_out    = data_out_q;
	assign status      = status_q;
	assign entry_count = count_q;
	assign is_empty    = no_entries;

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("entry count above capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept && (action == spq_pkg::ACT_ENQUEUE) && !is_full
		|=> count_q == $past(count_q) + 1'b1)
		else $error("enqueue did not grow the queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept && (action == spq_pkg::ACT_DEQUEUE || action == spq_pkg::ACT_PEEK)
		&& no_entries |=> status_q == spq_pkg::STATUS_EMPTY && data_out_q == '0)
		else $error("empty read not flagged");

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= spq_pkg::COUNT_WIDTH'(2)
		|-> $signed(cell_entry[0].prio) >= $signed(cell_entry[1].prio))
		else $error("front entries out of order");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_stall && !accept |=> rsp_valid_q)
		else $error("stalled result beat dropped");

endmodule
